>>> hdl/rgb_to_ansi_ascii_art_encoder_top_defines.svh
// assertion macros for the rgb to ansi ascii art encoder
`ifndef RGB_TO_ANSI_ASCII_ART_ENCODER_TOP_DEFINES_SVH
`define RGB_TO_ANSI_ASCII_ART_ENCODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define RTAA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RTAA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`else
`define RTAA_ASSERT(lbl, prop, msg)
`define RTAA_ASSERT_IMP(lbl, ante, cons, msg)
`endif

`endif

>>> hdl/rtaa_pkg.sv
// shared types, constants and functions of the rgb to ansi ascii art encoder
package rtaa_pkg;

  localparam int unsigned MaxColumns = 512;
  localparam int unsigned MaxRows    = 256;

  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 10;
  localparam int unsigned ColsW    = 10;
  localparam int unsigned RowsW    = 9;

  localparam logic [CfgIdxW-1:0] CFG_COLUMNS = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_ROWS    = 2'd1;

  localparam int unsigned NumSlots = 28;
  localparam int unsigned SlotW    = 5;
  localparam int unsigned QDepth   = 4;
  localparam int unsigned QPtrW    = 2;
  localparam int unsigned SumW     = 18;

  // byte slots of one pixel, in output order
  localparam logic [SlotW-1:0] SL_HOME    = 5'd0;
  localparam logic [SlotW-1:0] SL_SGR     = 5'd3;
  localparam logic [SlotW-1:0] SL_RED     = 5'd10;
  localparam logic [SlotW-1:0] SL_SEP_G   = 5'd13;
  localparam logic [SlotW-1:0] SL_GREEN   = 5'd14;
  localparam logic [SlotW-1:0] SL_SEP_B   = 5'd17;
  localparam logic [SlotW-1:0] SL_BLUE    = 5'd18;
  localparam logic [SlotW-1:0] SL_SGR_END = 5'd21;
  localparam logic [SlotW-1:0] SL_GLYPH   = 5'd22;
  localparam logic [SlotW-1:0] SL_NEWLINE = 5'd23;
  localparam logic [SlotW-1:0] SL_RESET   = 5'd24;

  localparam logic [7:0] CH_ESC  = 8'h1B;
  localparam logic [7:0] CH_LBR  = 8'h5B;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_M    = 8'h6D;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_ZERO = 8'h30;

  localparam logic [7:0] HOME_SEQ [3]  = '{CH_ESC, CH_LBR, 8'h48};
  localparam logic [7:0] SGR_SEQ [7]   = '{CH_ESC, CH_LBR, 8'h33, 8'h38, CH_SEMI, 8'h32, CH_SEMI};
  localparam logic [7:0] RESET_SEQ [4] = '{CH_ESC, CH_LBR, CH_ZERO, CH_M};

  localparam logic [7:0] RAMP [10] = '{8'h20, 8'h2E, 8'h3A, 8'h2D, 8'h3D,
                                       8'h2B, 8'h2A, 8'h23, 8'h25, 8'h40};

  // weighted sum at which each ramp step begins: 1000 * ceil(255 * k / 9)
  localparam logic [SumW-1:0] LUMA_STEP [9] = '{18'd29000, 18'd57000, 18'd85000,
                                                18'd114000, 18'd142000, 18'd170000,
                                                18'd199000, 18'd227000, 18'd255000};

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
  } byte_item_t;

  typedef struct packed {
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] ones;
  } dec_t;

  typedef struct packed {
    dec_t       red;
    dec_t       green;
    dec_t       blue;
    logic [7:0] glyph;
  } emit_data_t;

  typedef struct packed {
    logic [NumSlots-1:0] mask;
    emit_data_t          data;
  } desc_t;

  function automatic dec_t to_dec(input logic [7:0] v);
    dec_t       d;
    logic [7:0] rem;
    d = '0;
    if (v >= 8'd200) begin
      d.hund = 4'd2;
      rem    = v - 8'd200;
    end else if (v >= 8'd100) begin
      d.hund = 4'd1;
      rem    = v - 8'd100;
    end else begin
      rem = v;
    end
    for (int k = 1; k < 10; k++) begin
      if (rem >= 8'(10 * k)) begin
        d.tens = 4'(k);
      end
    end
    d.ones = 4'(rem - (8'(d.tens) * 8'd10));
    return d;
  endfunction

  function automatic logic [7:0] glyph_of(input logic [SumW-1:0] sum);
    logic [3:0] idx;
    idx = '0;
    for (int k = 0; k < 9; k++) begin
      if (sum >= LUMA_STEP[k]) begin
        idx = 4'(k + 1);
      end
    end
    return RAMP[idx];
  endfunction

  function automatic logic [7:0] digit_byte(input dec_t d, input logic [1:0] pos);
    logic [3:0] n;
    case (pos)
      2'd0:    n = d.hund;
      2'd1:    n = d.tens;
      default: n = d.ones;
    endcase
    return CH_ZERO + {4'h0, n};
  endfunction

  function automatic logic [7:0] slot_byte(input logic [SlotW-1:0] slot,
                                          input emit_data_t d);
    logic [7:0] b;
    if (slot < SL_SGR) begin
      b = HOME_SEQ[2'(slot - SL_HOME)];
    end else if (slot < SL_RED) begin
      b = SGR_SEQ[3'(slot - SL_SGR)];
    end else if (slot < SL_SEP_G) begin
      b = digit_byte(d.red, 2'(slot - SL_RED));
    end else if (slot == SL_SEP_G || slot == SL_SEP_B) begin
      b = CH_SEMI;
    end else if (slot < SL_SEP_B) begin
      b = digit_byte(d.green, 2'(slot - SL_GREEN));
    end else if (slot < SL_SGR_END) begin
      b = digit_byte(d.blue, 2'(slot - SL_BLUE));
    end else if (slot == SL_SGR_END) begin
      b = CH_M;
    end else if (slot == SL_GLYPH) begin
      b = d.glyph;
    end else if (slot == SL_NEWLINE) begin
      b = CH_NL;
    end else begin
      b = RESET_SEQ[2'(slot - SL_RESET)];
    end
    return b;
  endfunction

endpackage

>>> hdl/rtaa_front.sv
// front end: takes pixels, tracks position and color, builds byte descriptors
module rtaa_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtaa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtaa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  rtaa_pkg::pixel_t              pix_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output rtaa_pkg::desc_t               q_desc_o
);
  import rtaa_pkg::*;

  logic [ColsW-1:0] columns_q;
  logic [RowsW-1:0] rows_q;
  logic [8:0]       col_q, col_d;
  logic [7:0]       row_q, row_d;
  pixel_t           prev_q, prev_d;

  logic             st_valid_q;
  pixel_t           st_pix_q;
  logic [SumW-1:0]  st_sum_q;
  logic             st_home_q, st_chg_q, st_row_end_q, st_frame_end_q;

  logic [ColsW-1:0] cols_eff, col_next;
  logic [RowsW-1:0] rows_eff, row_next;
  logic             accept, row_end, frame_end, home, chg;
  logic [SumW-1:0]  sum;

  assign cols_eff = (columns_q == '0) ? ColsW'(1) :
                    (columns_q > ColsW'(MaxColumns)) ? ColsW'(MaxColumns) : columns_q;
  assign rows_eff = (rows_q == '0) ? RowsW'(1) :
                    (rows_q > RowsW'(MaxRows)) ? RowsW'(MaxRows) : rows_q;

  assign col_next  = {1'b0, col_q} + ColsW'(1);
  assign row_next  = {1'b0, row_q} + RowsW'(1);
  assign row_end   = col_next >= cols_eff;
  assign frame_end = row_end && (row_next >= rows_eff);
  assign home      = (col_q == '0) && (row_q == '0);
  assign chg       = pix_i != prev_q;
  assign sum       = SumW'(pix_i.red) * SumW'(299) + SumW'(pix_i.green) * SumW'(587)
                   + SumW'(pix_i.blue) * SumW'(114);

  assign pix_ready_o = !st_valid_q || q_ready_i;
  assign accept      = pix_valid_i && pix_ready_o;

  always_comb begin
    col_d  = col_q;
    row_d  = row_q;
    prev_d = prev_q;
    if (accept) begin
      prev_d = pix_i;
      if (row_end) begin
        col_d = '0;
        row_d = frame_end ? '0 : row_next[7:0];
      end else begin
        col_d = col_next[8:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q  <= ColsW'(80);
      rows_q     <= RowsW'(24);
      col_q      <= '0;
      row_q      <= '0;
      prev_q     <= '0;
      st_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == CFG_COLUMNS) begin
        columns_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == CFG_ROWS) begin
        rows_q <= cfg_data_i[RowsW-1:0];
      end
      col_q  <= col_d;
      row_q  <= row_d;
      prev_q <= prev_d;
      if (pix_ready_o) begin
        st_valid_q <= pix_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_pix_q       <= pix_i;
      st_sum_q       <= sum;
      st_home_q      <= home;
      st_chg_q       <= chg;
      st_row_end_q   <= row_end;
      st_frame_end_q <= frame_end;
    end
  end

  always_comb begin
    q_desc_o.mask                   = '0;
    q_desc_o.mask[SL_HOME +: 3]     = {3{st_home_q}};
    q_desc_o.mask[SL_SGR +: 7]      = {7{st_chg_q}};
    q_desc_o.mask[SL_RED]           = st_chg_q && (st_pix_q.red >= 8'd100);
    q_desc_o.mask[SL_RED + 5'd1]    = st_chg_q && (st_pix_q.red >= 8'd10);
    q_desc_o.mask[SL_RED + 5'd2]    = st_chg_q;
    q_desc_o.mask[SL_SEP_G]         = st_chg_q;
    q_desc_o.mask[SL_GREEN]         = st_chg_q && (st_pix_q.green >= 8'd100);
    q_desc_o.mask[SL_GREEN + 5'd1]  = st_chg_q && (st_pix_q.green >= 8'd10);
    q_desc_o.mask[SL_GREEN + 5'd2]  = st_chg_q;
    q_desc_o.mask[SL_SEP_B]         = st_chg_q;
    q_desc_o.mask[SL_BLUE]          = st_chg_q && (st_pix_q.blue >= 8'd100);
    q_desc_o.mask[SL_BLUE + 5'd1]   = st_chg_q && (st_pix_q.blue >= 8'd10);
    q_desc_o.mask[SL_BLUE + 5'd2]   = st_chg_q;
    q_desc_o.mask[SL_SGR_END]       = st_chg_q;
    q_desc_o.mask[SL_GLYPH]         = 1'b1;
    q_desc_o.mask[SL_NEWLINE]       = st_row_end_q;
    q_desc_o.mask[SL_RESET +: 4]    = {4{st_frame_end_q}};
    q_desc_o.data.red               = to_dec(st_pix_q.red);
    q_desc_o.data.green             = to_dec(st_pix_q.green);
    q_desc_o.data.blue              = to_dec(st_pix_q.blue);
    q_desc_o.data.glyph             = glyph_of(st_sum_q);
  end

  assign q_valid_o = st_valid_q;

endmodule

>>> hdl/rtaa_queue.sv
// short descriptor queue between front and back
module rtaa_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  output logic            push_ready_o,
  input  rtaa_pkg::desc_t push_desc_i,
  output logic            pop_valid_o,
  input  logic            pop_ready_i,
  output rtaa_pkg::desc_t pop_desc_o
);
  import rtaa_pkg::*;

  desc_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPtrW:0]   count_q;
  logic             push, pop;

  assign push_ready_o = count_q != (QPtrW + 1)'(QDepth);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_desc_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_desc_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QPtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QPtrW'(1);
      end
      if (push && !pop) begin
        count_q <= count_q + (QPtrW + 1)'(1);
      end else if (pop && !push) begin
        count_q <= count_q - (QPtrW + 1)'(1);
      end
    end
  end

endmodule

>>> hdl/rtaa_back.sv
// back end: walks a descriptor's byte slots and drives the output register
`include "rgb_to_ansi_ascii_art_encoder_top_defines.svh"

module rtaa_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_valid_i,
  output logic                 q_ready_o,
  input  rtaa_pkg::desc_t      q_desc_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output rtaa_pkg::byte_item_t out_o
);
  import rtaa_pkg::*;

  logic [NumSlots-1:0] mask_q, mask_d, mask_clr;
  emit_data_t          data_q;
  logic                out_valid_q, out_valid_d;
  byte_item_t          out_item_q, out_item_d;
  logic [SlotW-1:0]    slot;
  logic                busy, adv, last_now, pop;

  always_comb begin
    slot = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (mask_q[i]) begin
        slot = SlotW'(i);
      end
    end
  end

  assign mask_clr  = mask_q & (mask_q - NumSlots'(1));
  assign busy      = mask_q != '0;
  assign last_now  = busy && (mask_clr == '0);
  assign adv       = !out_valid_q || out_ready_i;
  assign q_ready_o = adv && (!busy || last_now);
  assign pop       = q_ready_o && q_valid_i;

  always_comb begin
    mask_d      = mask_q;
    out_valid_d = out_valid_q;
    out_item_d  = out_item_q;
    if (adv) begin
      out_valid_d = busy;
      if (busy) begin
        out_item_d.out_byte = slot_byte(slot, data_q);
        out_item_d.last     = last_now;
        mask_d              = mask_clr;
      end
    end
    if (pop) begin
      mask_d = q_desc_i.mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
    if (pop) begin
      data_q <= q_desc_i.data;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_item_q;

  `RTAA_ASSERT_IMP(a_rest_pending, out_valid_q && !out_item_q.last, mask_q != '0, "bytes of item lost")
  `RTAA_ASSERT(a_busy_emits, (busy && adv) |=> out_valid_q, "pending byte not shown")
  `RTAA_ASSERT(a_idle_after_last, (adv && last_now && !q_valid_i) |=> (mask_q == '0), "slot left after last byte")

endmodule

>>> hdl/rgb_to_ansi_ascii_art_encoder_top.sv
// top level of the rgb to ansi ascii art encoder
//
//   channel  dir  handshake                 payload
//   pixel    in   pix_valid_i / pix_ready_o pix_i (red, green, blue)
//   bytes    out  out_valid_o / out_ready_i out_o (out_byte, last)
//   config   in   cfg_we_i                  cfg_index_i, cfg_data_i
//
// one output byte per cycle unless out_ready_i stalls it; a pixel causes 1 to 28 bytes, one per slot
// the byte sequencer in the back end sets the rate; the front end takes a pixel a cycle while the queue has room
// a pixel reaches its first byte through stage, queue, slot mask and output register
// reset restores 80 columns, 24 rows, black color memory and the top left position
// the four-entry queue lets the front keep taking pixels while the output stalls, until the queue fills
module rgb_to_ansi_ascii_art_encoder_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rtaa_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [rtaa_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          pix_valid_i,
  output logic                          pix_ready_o,
  input  rtaa_pkg::pixel_t              pix_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rtaa_pkg::byte_item_t          out_o
);
  import rtaa_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  desc_t push_desc, pop_desc;

  rtaa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pix_valid_i (pix_valid_i),
    .pix_ready_o (pix_ready_o),
    .pix_i       (pix_i),
    .q_valid_o   (push_valid),
    .q_ready_i   (push_ready),
    .q_desc_o    (push_desc)
  );

  rtaa_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_desc_i  (push_desc),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_desc_o   (pop_desc)
  );

  rtaa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (pop_valid),
    .q_ready_o   (pop_ready),
    .q_desc_i    (pop_desc),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule
